[rtl/ftl_pkg.sv]
`timescale 1ns / 1ps

package ftl_pkg;

    // default geometry
    localparam int DEF_NUM_BLOCKS      = 6;
    localparam int DEF_PAGES_PER_BLOCK = 4;
    localparam int DEF_NUM_ADDRESSES   = 16;

    // widest logical address any geometry can need
    localparam int ADDR_W_MAX = 10;

    // fixed field widths
    localparam int LBA_IN_W  = 4;
    localparam int STATUS_W  = 2;
    localparam int PAGE_W    = 5;
    localparam int MOVED_W   = 6;
    localparam int ERASED_W  = 4;
    localparam int TOTAL_W   = 32;
    localparam int WEAR_W    = 16;
    localparam int MINER_W   = 2;

    localparam logic [MINER_W-1:0] MIN_ERASED_RST = 2'd2;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TRIM  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd2;

    // page states
    localparam logic [1:0] PG_FREE  = 2'd0;
    localparam logic [1:0] PG_VALID = 2'd1;
    localparam logic [1:0] PG_STALE = 2'd2;

    // register index of the threshold register
    localparam int REG_MIN_ERASED = 0;

    // queued request between front and back
    typedef struct packed {
        logic                  trim;
        logic [ADDR_W_MAX-1:0] addr;
    } ftl_req_t;

endpackage

[rtl/page_mapped_ftl_with_gc.sv]
`timescale 1ns / 1ps

// Channel   | Signals                                        | Handshake
// ----------+------------------------------------------------+--------------------------
// request   | command, logical_address                       | start && !busy
// result    | status, page_written, pages_relocated,         | done, one cycle, no stall
//           | blocks_erased, host_write_total, nand_write_total |
// config    | psel, penable, pwrite, paddr, pwdata, prdata    | APB, pready tied high
//
// A write without collection runs an erased-block scan, the space check, the program,
// a second erased-block scan and the threshold check. Each collection round adds a victim
// page scan, an evaluation, a pass over the victim's pages that programs each valid one,
// an erase and an erased-block scan. Any program that opens a block adds an erased-block
// scan. Reset (rst_n low) clears page states, fills, wear and mapped flags at once; no clearing pass follows.
// A two-request queue takes new requests while the sequencer works; busy rises when full.

module page_mapped_ftl_with_gc
    import ftl_pkg::*;
#(
    parameter int NUM_BLOCKS      = DEF_NUM_BLOCKS,
    parameter int PAGES_PER_BLOCK = DEF_PAGES_PER_BLOCK,
    parameter int NUM_ADDRESSES   = DEF_NUM_ADDRESSES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic [LBA_IN_W-1:0] logical_address,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [PAGE_W-1:0]   page_written,
    output logic [MOVED_W-1:0]  pages_relocated,
    output logic [ERASED_W-1:0] blocks_erased,
    output logic [TOTAL_W-1:0]  host_write_total,
    output logic [TOTAL_W-1:0]  nand_write_total,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic               req_valid;
    logic               req_pop;
    ftl_req_t           req;
    logic [MINER_W-1:0] min_erased_reg;
    logic               cfg_wr;

    // config register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'(REG_MIN_ERASED));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_erased_reg <= MIN_ERASED_RST;
        end
        else if (cfg_wr)
        begin
            min_erased_reg <= pwdata[MINER_W-1:0];
        end
    end

    assign prdata = {{(32 - MINER_W){1'b0}}, min_erased_reg};

    ftl_front #(
        .NUM_ADDRESSES  (NUM_ADDRESSES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .logical_address (logical_address),
        .req_valid       (req_valid),
        .req             (req),
        .req_pop         (req_pop)
    );

    ftl_back #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
        .NUM_ADDRESSES   (NUM_ADDRESSES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req              (req),
        .req_pop          (req_pop),
        .min_erased       (min_erased_reg),
        .done             (done),
        .status           (status),
        .page_written     (page_written),
        .pages_relocated  (pages_relocated),
        .blocks_erased    (blocks_erased),
        .host_write_total (host_write_total),
        .nand_write_total (nand_write_total)
    );

    // results never come back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    // every host write is also a page program
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (nand_write_total >= host_write_total))
        else $error("program total below host write total");

    // an ignored trim does no work
    a_trim_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_UNMAPPED)) |->
            ((page_written == '0) && (pages_relocated == '0) && (blocks_erased == '0)))
        else $error("ignored trim reported work");

endmodule

[rtl/ftl_front.sv]
`timescale 1ns / 1ps

module ftl_front
    import ftl_pkg::*;
#(
    parameter int NUM_ADDRESSES = DEF_NUM_ADDRESSES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic [LBA_IN_W-1:0] logical_address,
    output logic                req_valid,
    output ftl_req_t            req,
    input  logic                req_pop
);

    localparam int AW = (NUM_ADDRESSES > 1) ? $clog2(NUM_ADDRESSES) : 1;
    localparam int LBA_N = 1 << LBA_IN_W;

    // address folding table, built at elaboration
    logic [AW-1:0] mod_tab [LBA_N];
    for (genvar i = 0; i < LBA_N; i++) begin : g_mod
        assign mod_tab[i] = AW'(i % NUM_ADDRESSES);
    end

    // two-entry request queue
    ftl_req_t   q_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    ftl_req_t   in_req;

    assign busy      = (cnt_reg == 2'd2);
    assign push      = start && !busy;
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rp_reg];

    always_comb
    begin
        in_req      = '0;
        in_req.trim = (command == CMD_TRIM);
        in_req.addr = ADDR_W_MAX'(mod_tab[logical_address]);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (req_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(req_pop);
        end
    end

endmodule

[rtl/ftl_back.sv]
`timescale 1ns / 1ps

module ftl_back
    import ftl_pkg::*;
#(
    parameter int NUM_BLOCKS      = DEF_NUM_BLOCKS,
    parameter int PAGES_PER_BLOCK = DEF_PAGES_PER_BLOCK,
    parameter int NUM_ADDRESSES   = DEF_NUM_ADDRESSES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  ftl_req_t            req,
    output logic                req_pop,
    input  logic [MINER_W-1:0]  min_erased,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [PAGE_W-1:0]   page_written,
    output logic [MOVED_W-1:0]  pages_relocated,
    output logic [ERASED_W-1:0] blocks_erased,
    output logic [TOTAL_W-1:0]  host_write_total,
    output logic [TOTAL_W-1:0]  nand_write_total
);

    localparam int TP   = NUM_BLOCKS * PAGES_PER_BLOCK;
    localparam int AW   = (NUM_ADDRESSES > 1) ? $clog2(NUM_ADDRESSES) : 1;
    localparam int BW   = $clog2(NUM_BLOCKS + 1);
    localparam int BIW  = $clog2(NUM_BLOCKS);
    localparam int PIW  = $clog2(PAGES_PER_BLOCK);
    localparam int PGW  = $clog2(TP);
    localparam int FW   = $clog2(PAGES_PER_BLOCK + 1);
    localparam int RW   = $clog2(PAGES_PER_BLOCK * (NUM_BLOCKS + 1) + 1);
    localparam logic [BW-1:0]  NONE    = BW'(NUM_BLOCKS);
    localparam logic [BW-1:0]  LAST_B  = BW'(NUM_BLOCKS - 1);
    localparam logic [PIW-1:0] LAST_P  = PIW'(PAGES_PER_BLOCK - 1);
    localparam logic [FW-1:0]  FULL    = FW'(PAGES_PER_BLOCK);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_TRIM    = 13'b0000000000010,
        S_ESCAN   = 13'b0000000000100,
        S_WCHK    = 13'b0000000001000,
        S_PROG    = 13'b0000000010000,
        S_POPEN   = 13'b0000000100000,
        S_GCSTART = 13'b0000001000000,
        S_GCHK    = 13'b0000010000000,
        S_VSCAN   = 13'b0000100000000,
        S_VEVAL   = 13'b0001000000000,
        S_MOVE    = 13'b0010000000000,
        S_ERASE   = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    state_t state_reg, ret_reg, pret_reg;

    // flash bookkeeping
    logic [1:0]        pstat_reg  [TP];
    logic [AW-1:0]     owner_reg  [TP];
    logic [FW-1:0]     fill_reg   [NUM_BLOCKS];
    logic [WEAR_W-1:0] wear_reg   [NUM_BLOCKS];
    logic [PGW-1:0]    map_reg    [NUM_ADDRESSES];
    logic              mapped_reg [NUM_ADDRESSES];
    logic [BW-1:0]     open_reg;

    // sequencer working registers
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     powner_reg;
    logic              hostw_reg;
    logic [BW-1:0]     blk_reg;
    logic [PIW-1:0]    pidx_reg;
    logic [BW-1:0]     cnt_reg;
    logic [BW-1:0]     best_reg;
    logic [WEAR_W-1:0] bestw_reg;
    logic [FW-1:0]     stale_reg;
    logic [FW-1:0]     valid_reg;
    logic [FW-1:0]     most_reg;
    logic [BW-1:0]     vic_reg;
    logic [WEAR_W-1:0] vicw_reg;
    logic [FW-1:0]     vvalid_reg;

    // result registers
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [PGW-1:0]      written_reg;
    logic [MOVED_W-1:0]  moved_reg;
    logic [ERASED_W-1:0] erased_reg;
    logic [TOTAL_W-1:0]  host_cnt_reg;
    logic [TOTAL_W-1:0]  prog_cnt_reg;

    // programming path
    logic [BW-1:0]  pb;
    logic           open_full;
    logic           do_prog;
    logic [PGW-1:0] ppn;

    // scan helpers
    logic [PGW-1:0] scan_pg;
    logic [1:0]     scan_st;
    logic [FW-1:0]  stale_next;
    logic [FW-1:0]  valid_next;
    logic [PGW-1:0] mv_pg;
    logic           mv_last;
    logic [RW-1:0]  room;
    logic [PGW-1:0] old_pg;

    assign req_pop = (state_reg == S_IDLE) && req_valid;

    always_comb
    begin
        open_full  = (fill_reg[open_reg[BIW-1:0]] >= FULL);
        pb         = (state_reg == S_POPEN) ? best_reg : open_reg;
        do_prog    = ((state_reg == S_PROG) && !open_full) || (state_reg == S_POPEN);
        ppn        = PGW'(pb * PAGES_PER_BLOCK) + PGW'(fill_reg[pb[BIW-1:0]]);
        scan_pg    = PGW'(blk_reg * PAGES_PER_BLOCK) + PGW'(pidx_reg);
        scan_st    = pstat_reg[scan_pg];
        stale_next = stale_reg + FW'(scan_st == PG_STALE);
        valid_next = valid_reg + FW'(scan_st == PG_VALID);
        mv_pg      = PGW'(vic_reg * PAGES_PER_BLOCK) + PGW'(pidx_reg);
        mv_last    = (pidx_reg == LAST_P);
        room       = RW'(FULL - fill_reg[open_reg[BIW-1:0]])
                   + RW'(cnt_reg * PAGES_PER_BLOCK);
        old_pg     = map_reg[addr_reg];
    end

    // payload stores without reset
    always_ff @(posedge clk)
    begin
        if (do_prog)
        begin
            owner_reg[ppn]      <= powner_reg;
            map_reg[powner_reg] <= ppn;
        end
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            pret_reg     <= S_IDLE;
            for (int i = 0; i < TP; i++)
            begin
                pstat_reg[i] <= PG_FREE;
            end
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                fill_reg[i] <= '0;
                wear_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_ADDRESSES; i++)
            begin
                mapped_reg[i] <= 1'b0;
            end
            open_reg     <= '0;
            addr_reg     <= '0;
            powner_reg   <= '0;
            hostw_reg    <= 1'b0;
            blk_reg      <= '0;
            pidx_reg     <= '0;
            cnt_reg      <= '0;
            best_reg     <= NONE;
            bestw_reg    <= '0;
            stale_reg    <= '0;
            valid_reg    <= '0;
            most_reg     <= '0;
            vic_reg      <= NONE;
            vicw_reg     <= '0;
            vvalid_reg   <= '0;
            done_reg     <= 1'b0;
            status_reg   <= ST_DONE;
            written_reg  <= '0;
            moved_reg    <= '0;
            erased_reg   <= '0;
            host_cnt_reg <= '0;
            prog_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            // one page program into the open (or newly opened) block
            if (do_prog)
            begin
                pstat_reg[ppn]              <= PG_VALID;
                fill_reg[pb[BIW-1:0]]       <= fill_reg[pb[BIW-1:0]] + 1'b1;
                mapped_reg[powner_reg]      <= 1'b1;
                if (prog_cnt_reg != '1)
                begin
                    prog_cnt_reg <= prog_cnt_reg + 1'b1;
                end
                if (hostw_reg)
                begin
                    written_reg <= ppn;
                end
                hostw_reg <= 1'b0;
                open_reg  <= pb;
                state_reg <= pret_reg;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        addr_reg    <= AW'(req.addr);
                        status_reg  <= ST_DONE;
                        written_reg <= '0;
                        moved_reg   <= '0;
                        erased_reg  <= '0;
                        if (req.trim)
                        begin
                            state_reg <= S_TRIM;
                        end
                        else
                        begin
                            blk_reg   <= '0;
                            cnt_reg   <= '0;
                            best_reg  <= NONE;
                            ret_reg   <= S_WCHK;
                            state_reg <= S_ESCAN;
                        end
                    end
                end

                S_TRIM:
                begin
                    if (mapped_reg[addr_reg])
                    begin
                        pstat_reg[old_pg]    <= PG_STALE;
                        mapped_reg[addr_reg] <= 1'b0;
                    end
                    else
                    begin
                        status_reg <= ST_UNMAPPED;
                    end
                    state_reg <= S_DONE;
                end

                // erased-block count and least-worn erased block
                S_ESCAN:
                begin
                    if ((blk_reg != open_reg) && (fill_reg[blk_reg[BIW-1:0]] == '0))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if ((best_reg == NONE) || (wear_reg[blk_reg[BIW-1:0]] < bestw_reg))
                        begin
                            best_reg  <= blk_reg;
                            bestw_reg <= wear_reg[blk_reg[BIW-1:0]];
                        end
                    end
                    if (blk_reg == LAST_B)
                    begin
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        blk_reg <= blk_reg + 1'b1;
                    end
                end

                S_WCHK:
                begin
                    if (open_full && (best_reg == NONE))
                    begin
                        status_reg <= ST_NOSPACE;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        if (host_cnt_reg != '1)
                        begin
                            host_cnt_reg <= host_cnt_reg + 1'b1;
                        end
                        if (mapped_reg[addr_reg])
                        begin
                            pstat_reg[old_pg] <= PG_STALE;
                        end
                        powner_reg <= addr_reg;
                        hostw_reg  <= 1'b1;
                        pret_reg   <= S_GCSTART;
                        state_reg  <= S_PROG;
                    end
                end

                S_PROG:
                begin
                    // full open block: find a fresh one first
                    if (open_full)
                    begin
                        blk_reg   <= '0;
                        cnt_reg   <= '0;
                        best_reg  <= NONE;
                        ret_reg   <= S_POPEN;
                        state_reg <= S_ESCAN;
                    end
                end

                S_POPEN:
                begin
                end

                S_GCSTART:
                begin
                    blk_reg   <= '0;
                    cnt_reg   <= '0;
                    best_reg  <= NONE;
                    ret_reg   <= S_GCHK;
                    state_reg <= S_ESCAN;
                end

                S_GCHK:
                begin
                    if ((min_erased == '0) || (cnt_reg >= BW'(min_erased)))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        blk_reg   <= '0;
                        pidx_reg  <= '0;
                        stale_reg <= '0;
                        valid_reg <= '0;
                        most_reg  <= '0;
                        vic_reg   <= NONE;
                        state_reg <= S_VSCAN;
                    end
                end

                // greedy victim search, one page a cycle
                S_VSCAN:
                begin
                    if (pidx_reg == LAST_P)
                    begin
                        if ((blk_reg != open_reg)
                            && ((stale_next > most_reg)
                                || ((vic_reg != NONE) && (stale_next == most_reg)
                                    && (wear_reg[blk_reg[BIW-1:0]] < vicw_reg))))
                        begin
                            most_reg   <= stale_next;
                            vic_reg    <= blk_reg;
                            vicw_reg   <= wear_reg[blk_reg[BIW-1:0]];
                            vvalid_reg <= valid_next;
                        end
                        stale_reg <= '0;
                        valid_reg <= '0;
                        pidx_reg  <= '0;
                        if (blk_reg == LAST_B)
                        begin
                            state_reg <= S_VEVAL;
                        end
                        else
                        begin
                            blk_reg <= blk_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        stale_reg <= stale_next;
                        valid_reg <= valid_next;
                        pidx_reg  <= pidx_reg + 1'b1;
                    end
                end

                S_VEVAL:
                begin
                    if (vic_reg == NONE)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (RW'(vvalid_reg) > room)
                    begin
                        status_reg <= ST_NOSPACE;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        pidx_reg  <= '0;
                        state_reg <= S_MOVE;
                    end
                end

                // relocate valid pages of the victim
                S_MOVE:
                begin
                    pidx_reg <= mv_last ? '0 : pidx_reg + 1'b1;
                    if (pstat_reg[mv_pg] == PG_VALID)
                    begin
                        powner_reg <= owner_reg[mv_pg];
                        if (moved_reg != '1)
                        begin
                            moved_reg <= moved_reg + 1'b1;
                        end
                        pret_reg  <= mv_last ? S_ERASE : S_MOVE;
                        state_reg <= S_PROG;
                    end
                    else
                    begin
                        state_reg <= mv_last ? S_ERASE : S_MOVE;
                    end
                end

                S_ERASE:
                begin
                    for (int p = 0; p < PAGES_PER_BLOCK; p++)
                    begin
                        pstat_reg[PGW'(vic_reg * PAGES_PER_BLOCK) + PGW'(p)] <= PG_FREE;
                    end
                    fill_reg[vic_reg[BIW-1:0]] <= '0;
                    if (wear_reg[vic_reg[BIW-1:0]] != '1)
                    begin
                        wear_reg[vic_reg[BIW-1:0]] <= wear_reg[vic_reg[BIW-1:0]] + 1'b1;
                    end
                    if (erased_reg != '1)
                    begin
                        erased_reg <= erased_reg + 1'b1;
                    end
                    state_reg <= S_GCSTART;
                end

                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign page_written     = PAGE_W'(written_reg);
    assign pages_relocated  = moved_reg;
    assign blocks_erased    = erased_reg;
    assign host_write_total = host_cnt_reg;
    assign nand_write_total = prog_cnt_reg;

endmodule

[dv/page_mapped_ftl_with_gc_tb.sv]
`timescale 1ns / 1ps

module page_mapped_ftl_with_gc_tb;
    import ftl_pkg::*;

    localparam int NBLK  = DEF_NUM_BLOCKS;
    localparam int PPB   = DEF_PAGES_PER_BLOCK;
    localparam int NADDR = DEF_NUM_ADDRESSES;
    localparam int NPAGE = NBLK * PPB;
    localparam int NONE  = NBLK;
    localparam int SETTLE_CYCLES = 400;

    typedef struct packed {
        logic                cmd;
        logic [LBA_IN_W-1:0] lba;
    } ftl_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [PAGE_W-1:0]   page;
        logic [MOVED_W-1:0]  moved;
        logic [ERASED_W-1:0] erased;
        logic [TOTAL_W-1:0]  host_tot;
        logic [TOTAL_W-1:0]  nand_tot;
    } ftl_rsp_t;

    logic clk, rst_n;
    logic start, busy, command;
    logic [LBA_IN_W-1:0] logical_address;
    logic done;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page_written;
    logic [MOVED_W-1:0]  pages_relocated;
    logic [ERASED_W-1:0] blocks_erased;
    logic [TOTAL_W-1:0]  host_write_total, nand_write_total;
    logic psel, penable, pwrite, pready;
    logic [1:0]  paddr;
    logic [31:0] pwdata, prdata;

    page_mapped_ftl_with_gc dut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // shadow flash state
    logic [1:0]        pg_state [NPAGE];
    logic [3:0]        pg_owner [NPAGE];
    int unsigned       blk_fill [NBLK];
    logic [WEAR_W-1:0] blk_wear [NBLK];
    int unsigned       lba_ppn  [NADDR];
    bit                lba_live [NADDR];
    int unsigned       cur_blk;
    logic [TOTAL_W-1:0] host_cnt, prog_cnt;
    logic [MINER_W-1:0] gc_thresh;

    ftl_cmd_t pending_cmds [$];
    ftl_rsp_t expected_rsps [$];
    int unsigned n_sent;
    int unsigned n_errors;
    bit          sim_done;

    function automatic int unsigned spare_blocks();
        int unsigned n;
        n = 0;
        for (int i = 0; i < NBLK; i++)
            if (i != cur_blk && blk_fill[i] == 0) n++;
        return n;
    endfunction

    // least-worn erased block other than the open one
    function automatic int unsigned pick_spare();
        int unsigned b;
        b = NONE;
        for (int i = 0; i < NBLK; i++)
        begin
            if (i == cur_blk || blk_fill[i] != 0) continue;
            if (b == NONE || blk_wear[i] < blk_wear[b]) b = i;
        end
        return b;
    endfunction

    // most stale pages, ties to lower wear then lower index
    function automatic int unsigned pick_victim();
        int unsigned b, most, cnt;
        b = NONE;
        most = 0;
        for (int i = 0; i < NBLK; i++)
        begin
            if (i == cur_blk) continue;
            cnt = 0;
            for (int p = 0; p < PPB; p++)
                if (pg_state[i*PPB+p] == PG_STALE) cnt++;
            if (cnt > most || (b != NONE && cnt == most && blk_wear[i] < blk_wear[b]))
            begin
                most = cnt;
                b = i;
            end
        end
        return b;
    endfunction

    function automatic int unsigned program_lba(int unsigned lba);
        int unsigned ppn, b;
        if (blk_fill[cur_blk] >= PPB)
        begin
            b = pick_spare();
            if (b == NONE) return 0;
            cur_blk = b;
        end
        ppn = cur_blk * PPB + blk_fill[cur_blk];
        pg_state[ppn] = PG_VALID;
        pg_owner[ppn] = 4'(lba);
        blk_fill[cur_blk]++;
        lba_ppn[lba] = ppn;
        lba_live[lba] = 1'b1;
        if (prog_cnt != '1) prog_cnt++;
        return ppn;
    endfunction

    function automatic ftl_rsp_t ftl_execute(ftl_cmd_t c);
        ftl_rsp_t r;
        int unsigned lba, v, live, room;
        r = '0;
        lba = c.lba % NADDR;
        if (c.cmd == CMD_TRIM)
        begin
            if (!lba_live[lba])
                r.st = ST_UNMAPPED;
            else
            begin
                pg_state[lba_ppn[lba]] = PG_STALE;
                lba_live[lba] = 1'b0;
                lba_ppn[lba] = 0;
            end
        end
        else if (blk_fill[cur_blk] >= PPB && pick_spare() == NONE)
            r.st = ST_NOSPACE;
        else
        begin
            if (host_cnt != '1) host_cnt++;
            if (lba_live[lba]) pg_state[lba_ppn[lba]] = PG_STALE;
            r.page = PAGE_W'(program_lba(lba));
            // garbage collection loop
            while (spare_blocks() < gc_thresh)
            begin
                v = pick_victim();
                if (v == NONE) break;
                live = 0;
                for (int p = 0; p < PPB; p++)
                    if (pg_state[v*PPB+p] == PG_VALID) live++;
                room = (PPB - blk_fill[cur_blk]) + PPB * spare_blocks();
                if (live > room)
                begin
                    r.st = ST_NOSPACE;
                    break;
                end
                for (int p = 0; p < PPB; p++)
                    if (pg_state[v*PPB+p] == PG_VALID)
                    begin
                        void'(program_lba(pg_owner[v*PPB+p] % NADDR));
                        if (r.moved != '1) r.moved++;
                    end
                for (int p = 0; p < PPB; p++) pg_state[v*PPB+p] = PG_FREE;
                blk_fill[v] = 0;
                if (blk_wear[v] != '1) blk_wear[v]++;
                if (r.erased != '1) r.erased++;
            end
        end
        r.host_tot = host_cnt;
        r.nand_tot = prog_cnt;
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            command <= CMD_WRITE;
            logical_address <= '0;
            n_sent <= 0;
        end
        else
        begin
            bit holding;
            ftl_cmd_t c;
            holding = start;
            if (start && !busy)
            begin
                c.cmd = command;
                c.lba = logical_address;
                expected_rsps.push_back(ftl_execute(c));
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (pending_cmds.size() > 0 &&
                    ((n_sent > 300 && n_sent < 500) || $urandom_range(99) >= 24))
                begin
                    c = pending_cmds.pop_front();
                    start <= 1'b1;
                    command <= c.cmd;
                    logical_address <= c.lba;
                    n_sent <= n_sent + 1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            ftl_rsp_t got, exp_r;
            got = {status, page_written, pages_relocated, blocks_erased,
                   host_write_total, nand_write_total};
            if (expected_rsps.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                exp_r = expected_rsps.pop_front();
                if (got !== exp_r)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp st=%0d pg=%0d mv=%0d er=%0d h=%0d n=%0d",
                            exp_r.st, exp_r.page, exp_r.moved, exp_r.erased,
                            exp_r.host_tot, exp_r.nand_tot,
                            " / got st=%0d pg=%0d mv=%0d er=%0d h=%0d n=%0d",
                            got.st, got.page, got.moved, got.erased,
                            got.host_tot, got.nand_tot);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || start || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [MINER_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 2'(REG_MIN_ERASED * 4);
        pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        gc_thresh = val;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic queue_cmd(logic cmd, int unsigned lba);
        ftl_cmd_t c;
        c.cmd = cmd;
        c.lba = LBA_IN_W'(lba);
        pending_cmds.push_back(c);
    endtask

    // random burst, write heavy so collection and full-array cases show up
    task automatic queue_random(int unsigned n);
        for (int i = 0; i < n; i++)
            queue_cmd($urandom_range(99) < 25, $urandom_range(15));
    endtask

    initial
    begin
        logic [MINER_W-1:0] thresholds [5];
        thresholds = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3};
        for (int i = 0; i < NPAGE; i++)
        begin
            pg_state[i] = PG_FREE;
            pg_owner[i] = '0;
        end
        for (int i = 0; i < NBLK; i++)
        begin
            blk_fill[i] = 0;
            blk_wear[i] = '0;
        end
        for (int i = 0; i < NADDR; i++)
        begin
            lba_ppn[i] = 0;
            lba_live[i] = 1'b0;
        end
        cur_blk = 0;
        host_cnt = '0;
        prog_cnt = '0;
        gc_thresh = MIN_ERASED_RST;
        n_errors = 0;
        sim_done = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: unmapped trims, address extremes, overwrite, fill to force collection
        queue_cmd(CMD_TRIM, 0);
        queue_cmd(CMD_TRIM, 15);
        queue_cmd(CMD_WRITE, 0);
        queue_cmd(CMD_WRITE, 15);
        queue_cmd(CMD_WRITE, 0);
        queue_cmd(CMD_TRIM, 15);
        queue_cmd(CMD_TRIM, 15);
        for (int i = 0; i < 16; i++) queue_cmd(CMD_WRITE, i % 5);
        queue_cmd(CMD_TRIM, 0);
        wait_drained();

        // random phases across thresholds, including no-collection
        foreach (thresholds[k])
        begin
            write_threshold(thresholds[k]);
            queue_random(240);
            wait_drained();
        end

        sim_done = 1'b1;
        if (n_errors == 0)
            $display("page_mapped_ftl_with_gc_tb: PASS");
        else
            $display("page_mapped_ftl_with_gc_tb: FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        if (!sim_done)
        begin
            $display("page_mapped_ftl_with_gc_tb: FAIL");
            $finish;
        end
    end

endmodule

[filelist.f]
rtl/ftl_pkg.sv
rtl/ftl_front.sv
rtl/ftl_back.sv
rtl/page_mapped_ftl_with_gc.sv
dv/page_mapped_ftl_with_gc_tb.sv
